### hdl/fsp_pkg.sv
package fsp_pkg;

    localparam int NUM_SWITCHES_DEF = 8;

    localparam int LVL_W   = 4;
    localparam int IDX_W   = 4;
    localparam int PUMP_W  = 3;
    localparam int STATE_W = 8;

    localparam logic [PUMP_W-1:0] PUMP_MAX = 3'd7;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef struct packed {
        logic write_sw;
        logic clr_walk;
        logic step;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic changed;
        logic need_walk;
        logic walk_last;
    } t_sts;

endpackage

### hdl/fsp_ctrl.sv
module fsp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_op,
    input  logic          i_out_ready,
    input  fsp_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output fsp_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign accept      = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == fsp_pkg::OP_EVAL || i_sts.changed) begin
                        o_cmd.write_sw = (i_op == fsp_pkg::OP_SET);
                        o_cmd.clr_walk = 1'b1;
                        n_state = i_sts.need_walk ? S_WALK : S_EVAL;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.commit = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### hdl/fsp_dp.sv
module fsp_dp #(
    parameter int NUM_SWITCHES = fsp_pkg::NUM_SWITCHES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [fsp_pkg::LVL_W-1:0]     i_cfg_used_levels,
    input  logic [fsp_pkg::IDX_W-1:0]     i_switch_index,
    input  logic                          i_switch_level,
    input  fsp_pkg::t_cmd                 i_cmd,
    output fsp_pkg::t_sts                 o_sts,
    output logic [fsp_pkg::PUMP_W-1:0]    o_pumps_needed,
    output logic                          o_level_error,
    output logic [fsp_pkg::STATE_W-1:0]   o_switch_states
);

    localparam int SW_AW = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;
    localparam int LW    = fsp_pkg::LVL_W;

    logic [NUM_SWITCHES-1:0]   r_sw;
    logic [LW-1:0]             r_levels;
    logic [fsp_pkg::PUMP_W-1:0] r_pump, n_pump;
    logic                      r_err, n_err;
    logic                      r_run;
    logic                      r_werr;
    logic [LW-1:0]             r_cand;
    logic [LW-1:0]             r_cnt;
    logic [fsp_pkg::PUMP_W-1:0] r_o_pumps;
    logic                      r_o_err;
    logic [fsp_pkg::STATE_W-1:0] r_o_sw;

    logic                      idx_ok;
    logic [SW_AW-1:0]          wr_idx;
    logic [SW_AW-1:0]          walk_idx;
    logic                      walk_bit;
    logic                      top;
    logic [LW-1:0]             top_cand;
    logic [LW-1:0]             cand;
    logic [fsp_pkg::PUMP_W-1:0] cand_sat;
    logic [fsp_pkg::STATE_W-1:0] sw_view;

    assign idx_ok   = (32'(i_switch_index) < NUM_SWITCHES);
    assign wr_idx   = SW_AW'(i_switch_index);
    assign walk_idx = SW_AW'(r_cnt);
    assign walk_bit = r_sw[walk_idx];
    assign top      = r_sw[NUM_SWITCHES-1];

    assign o_sts.changed   = idx_ok && (r_sw[wr_idx] != i_switch_level);
    assign o_sts.need_walk = (r_levels >= LW'(2));
    assign o_sts.walk_last = ((LW+1)'(r_cnt) + (LW+1)'(2)) >= (LW+1)'(r_levels);

    assign top_cand = r_levels - LW'(1);
    assign cand     = top ? top_cand : r_cand;
    assign cand_sat = (cand > LW'(fsp_pkg::PUMP_MAX)) ? fsp_pkg::PUMP_MAX
                                                       : fsp_pkg::PUMP_W'(cand);

    always_comb begin
        if (r_levels < LW'(2) || NUM_SWITCHES < 2) begin
            n_err = 1'b0;
        end else begin
            n_err = r_werr || (!r_run && top);
        end
        n_pump = r_pump;
        case (r_levels)
            LW'(0): begin
                n_pump = '0;
            end
            LW'(1): begin
                n_pump = top ? fsp_pkg::PUMP_W'(1) : '0;
            end
            LW'(2): begin
                if (top) begin
                    n_pump = fsp_pkg::PUMP_W'(1);
                end else if (!r_sw[0]) begin
                    n_pump = '0;
                end
            end
            default: begin
                if (!r_sw[0]) begin
                    n_pump = '0;
                end else if (r_pump < cand_sat) begin
                    n_pump = cand_sat;
                end
            end
        endcase
    end

    for (genvar g = 0; g < fsp_pkg::STATE_W; g++) begin : g_view
        if (g < NUM_SWITCHES) begin : g_on
            assign sw_view[g] = r_sw[g];
        end else begin : g_off
            assign sw_view[g] = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sw     <= '0;
            r_levels <= LW'(NUM_SWITCHES > 15 ? 15 : NUM_SWITCHES);
            r_pump   <= '0;
            r_err    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (32'(i_cfg_used_levels) > NUM_SWITCHES) begin
                    r_levels <= LW'(NUM_SWITCHES);
                end else begin
                    r_levels <= i_cfg_used_levels;
                end
            end
            if (i_cmd.write_sw) begin
                r_sw[wr_idx] <= i_switch_level;
            end
            if (i_cmd.commit) begin
                r_pump <= n_pump;
                r_err  <= n_err;
            end
        end
    end

    // walk over switches 0..L-2, one per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_walk) begin
            r_cnt  <= '0;
            r_run  <= 1'b1;
            r_werr <= 1'b0;
            r_cand <= '0;
        end else if (i_cmd.step) begin
            r_cnt <= r_cnt + LW'(1);
            if (walk_bit) begin
                if (!r_run) begin
                    r_werr <= 1'b1;
                end
                if (r_cnt != '0) begin
                    r_cand <= r_cnt;
                end
            end else begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_pumps <= r_pump;
            r_o_err   <= r_err;
            r_o_sw    <= sw_view;
        end
    end

    assign o_pumps_needed  = r_o_pumps;
    assign o_level_error   = r_o_err;
    assign o_switch_states = r_o_sw;

endmodule

### hdl/float_switch_pump_staging.sv
// Float-switch pump staging.
// Input channel (i_in_valid/o_in_ready) carries one word: i_op selects a
// switch update (i_switch_index, i_switch_level) or a re-evaluation.
// Every accepted word yields exactly one result word on the output channel
// (o_out_valid/i_out_ready): pump count, error flag and switch states.
// Config channel (i_cfg_valid/o_cfg_ready) writes used_levels; always ready,
// takes effect at the next re-evaluation. Write it only while idle.
// A word that changes nothing goes straight to the finish state; a
// re-evaluation with L < 2 passes the evaluate state first, and one with
// L >= 2 walks before that, covering switches 0..L-2 one per cycle (L = used levels).
// One word is in work at a time; the next word is taken as soon as the
// result is registered, while that result still waits at the output.
// If the receiver stalls, a finished word holds in the controller until
// the output register frees up; input stays blocked meanwhile.
// Reset (synchronous, active low): all switches off, pump count and error
// zero, used levels = number of switches (capped at 15), output empty.
module float_switch_pump_staging #(
    parameter int NUM_SWITCHES = fsp_pkg::NUM_SWITCHES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_op,
    input  logic [fsp_pkg::IDX_W-1:0]     i_switch_index,
    input  logic                          i_switch_level,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [fsp_pkg::PUMP_W-1:0]    o_pumps_needed,
    output logic                          o_level_error,
    output logic [fsp_pkg::STATE_W-1:0]   o_switch_states,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [fsp_pkg::LVL_W-1:0]     i_cfg_used_levels
);

    fsp_pkg::t_cmd cmd;
    fsp_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    fsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_op),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    fsp_dp #(
        .NUM_SWITCHES (NUM_SWITCHES)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_used_levels (i_cfg_used_levels),
        .i_switch_index    (i_switch_index),
        .i_switch_level    (i_switch_level),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_pumps_needed    (o_pumps_needed),
        .o_level_error     (o_level_error),
        .o_switch_states   (o_switch_states)
    );

endmodule
